@@ hdl/multi_key_debounce_event_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the multi-key debounce event unit
// Shared property forms, all clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_KEY_DEBOUNCE_EVENT_UNIT_DEFINES_SVH
`define MULTI_KEY_DEBOUNCE_EVENT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MKD_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MKD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/mkd_pkg.sv @@
// ----------------------------------------------------------------------------
// mkd_pkg
// Types and constants shared by the key debounce channel and the top level.
// ----------------------------------------------------------------------------
package mkd_pkg;

  // Geometry of the payload and the register port.
  localparam int unsigned PIN_W         = 4;
  localparam int unsigned COUNT_W       = 4;
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned KEY_COUNT_DEF = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = 4'd15;
  localparam logic [COUNT_W-1:0] CONFIRM_RESET = 4'd3;

  // Per-key debounce phase.
  typedef enum logic [1:0] {
    PH_RELEASED   = 2'd0,
    PH_PRESS_DB   = 2'd1,
    PH_PRESSED    = 2'd2,
    PH_RELEASE_DB = 2'd3
  } key_phase_e;

  // Operation carried by each input item.
  typedef enum logic [1:0] {
    ACT_SCAN      = 2'd0,
    ACT_SCAN_READ = 2'd1,
    ACT_READ      = 2'd2,
    ACT_NONE      = 2'd3
  } action_e;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_SINGLE_SHOT   = 1'b0,
    REG_CONFIRM_COUNT = 1'b1
  } reg_idx_e;

  // Status of one key after the scan of the current item.
  typedef struct packed {
    logic pressed;
    logic pending;
  } key_status_t;

endpackage

@@ hdl/mkd_key.sv @@
// ----------------------------------------------------------------------------
// mkd_key
// Debounce state machine, sample counter and pending press event of one key.
// ----------------------------------------------------------------------------
`include "multi_key_debounce_event_unit_defines.svh"

module mkd_key (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          scan_i,
  input  logic                          level_i,
  input  logic [mkd_pkg::COUNT_W-1:0]   confirm_count_i,
  input  logic                          clear_i,
  output mkd_pkg::key_status_t          status_o
);

  mkd_pkg::key_phase_e           phase_q, phase_d;
  logic [mkd_pkg::COUNT_W-1:0]   count_q, count_d;
  logic [mkd_pkg::COUNT_W-1:0]   count_inc;
  logic                          pending_q;
  logic                          press_confirm;
  logic                          pending_scan;

  // Saturating increment of the sample counter.
  assign count_inc = (count_q == mkd_pkg::COUNT_MAX) ? count_q
                                                     : count_q + 1'b1;

  // Next phase and count for one scan tick; the level is active low.
  always_comb begin
    phase_d       = phase_q;
    count_d       = count_q;
    press_confirm = 1'b0;
    if (scan_i) begin
      unique case (phase_q)
        mkd_pkg::PH_RELEASED: begin
          if (!level_i) begin
            phase_d = mkd_pkg::PH_PRESS_DB;
            count_d = mkd_pkg::COUNT_W'(1);
          end
        end
        mkd_pkg::PH_PRESS_DB: begin
          if (!level_i) begin
            count_d = count_inc;
            if (count_inc >= confirm_count_i) begin
              phase_d       = mkd_pkg::PH_PRESSED;
              press_confirm = 1'b1;
            end
          end else begin
            phase_d = mkd_pkg::PH_RELEASED;
            count_d = '0;
          end
        end
        mkd_pkg::PH_PRESSED: begin
          if (level_i) begin
            phase_d = mkd_pkg::PH_RELEASE_DB;
            count_d = mkd_pkg::COUNT_W'(1);
          end
        end
        mkd_pkg::PH_RELEASE_DB: begin
          if (level_i) begin
            count_d = count_inc;
            if (count_inc >= confirm_count_i) begin
              phase_d = mkd_pkg::PH_RELEASED;
            end
          end else begin
            phase_d = mkd_pkg::PH_PRESSED;
            count_d = '0;
          end
        end
        default: begin
          phase_d = mkd_pkg::PH_RELEASED;
        end
      endcase
    end
  end

  // Status after the scan, seen by the event read in the same item.
  always_comb begin
    pending_scan     = pending_q | press_confirm;
    status_o.pressed = (phase_d == mkd_pkg::PH_PRESSED);
    status_o.pending = pending_scan;
  end

  // State advances once per item, as it leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mkd_pkg::PH_RELEASED;
      count_q   <= '0;
      pending_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      pending_q <= pending_scan & ~clear_i;
    end
  end

  `MKD_ASSERT_SAME(a_db_count_nonzero,
    (phase_q == mkd_pkg::PH_PRESS_DB) || (phase_q == mkd_pkg::PH_RELEASE_DB),
    count_q != '0, "debounce phase entered with a zero sample count")

endmodule

@@ hdl/multi_key_debounce_event_unit.sv @@
// ----------------------------------------------------------------------------
// multi_key_debounce_event_unit
// Path: an accepted item moves from the input register to the result register; it
// waits in the input register only while the result register awaits its own transfer.
// Throughput: one item per cycle while results are taken; all keys update in parallel in the same cycle.
// Reset: every key released with a zero count and no pending event,
// single_shot cleared and confirm_count set to three.
// Debounces active-low key pins, latches confirmed presses as events and
// reports the lowest pending event as a one-hot mask on a read.
// ----------------------------------------------------------------------------
`include "multi_key_debounce_event_unit_defines.svh"

module multi_key_debounce_event_unit #(
  parameter int unsigned KEY_COUNT = mkd_pkg::KEY_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mkd_pkg::ADDR_W-1:0]   paddr,
  input  logic [mkd_pkg::DATA_W-1:0]   pwdata,
  output logic [mkd_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic [mkd_pkg::PIN_W-1:0]    pin_levels_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mkd_pkg::PIN_W-1:0]    event_mask_o,
  output logic [mkd_pkg::PIN_W-1:0]    stable_pressed_o
);

  // Configuration registers.
  logic                          single_shot_q;
  logic [mkd_pkg::COUNT_W-1:0]   confirm_count_q;
  logic                          cfg_write;
  mkd_pkg::reg_idx_e             reg_idx;

  // Input register and result register.
  logic                          s1_valid_q;
  mkd_pkg::action_e              action_q;
  logic [mkd_pkg::PIN_W-1:0]     pins_q;
  logic                          s1_step;
  logic                          out_valid_q;
  logic [mkd_pkg::PIN_W-1:0]     mask_q, mask_d;
  logic [mkd_pkg::PIN_W-1:0]     stable_q, stable_d;

  // Key array signals.
  logic                          do_scan;
  logic                          do_read;
  mkd_pkg::key_status_t          status [KEY_COUNT];
  logic [KEY_COUNT-1:0]          cand;
  logic [KEY_COUNT-1:0]          grant;

  // --------------------------------------------------------------------------
  // Register port: writes land in the access phase, reads are combinational.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign reg_idx   = mkd_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      mkd_pkg::REG_SINGLE_SHOT:   prdata = {{(mkd_pkg::DATA_W-1){1'b0}}, single_shot_q};
      mkd_pkg::REG_CONFIRM_COUNT: prdata = {{(mkd_pkg::DATA_W-mkd_pkg::COUNT_W){1'b0}},
                                            confirm_count_q};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_shot_q   <= 1'b0;
      confirm_count_q <= mkd_pkg::CONFIRM_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        mkd_pkg::REG_SINGLE_SHOT:   single_shot_q   <= pwdata[0];
        mkd_pkg::REG_CONFIRM_COUNT: confirm_count_q <= pwdata[mkd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the item in the input register moves on whenever the result
  // register is empty or its result is being transferred.
  // --------------------------------------------------------------------------
  assign s1_step    = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | s1_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= mkd_pkg::action_e'(action_i);
      pins_q   <= pin_levels_i;
    end
  end

  // Action decode.
  always_comb begin
    do_scan = 1'b0;
    do_read = 1'b0;
    unique case (action_q)
      mkd_pkg::ACT_SCAN:      do_scan = 1'b1;
      mkd_pkg::ACT_SCAN_READ: begin
        do_scan = 1'b1;
        do_read = 1'b1;
      end
      mkd_pkg::ACT_READ:      do_read = 1'b1;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // One debounce channel per key; keys beyond the pin field read as released.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    logic level;
    if (k < mkd_pkg::PIN_W) begin : g_pin
      assign level = pins_q[k];
    end else begin : g_idle
      assign level = 1'b1;
    end

    mkd_key u_key (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .step_i          (s1_step),
      .scan_i          (do_scan),
      .level_i         (level),
      .confirm_count_i (confirm_count_q),
      .clear_i         (grant[k]),
      .status_o        (status[k])
    );

    // In single-shot mode a key still held down is not reported.
    assign cand[k] = status[k].pending & (~single_shot_q | ~status[k].pressed);
  end

  // Lowest pending event wins: isolate the lowest set bit.
  assign grant = do_read ? (cand & (~cand + 1'b1)) : '0;

  // Result fields, limited to the keys that have a pin.
  for (genvar j = 0; j < mkd_pkg::PIN_W; j++) begin : g_out
    if (j < KEY_COUNT) begin : g_live
      assign mask_d[j]   = grant[j];
      assign stable_d[j] = status[j].pressed;
    end else begin : g_pad
      assign mask_d[j]   = 1'b0;
      assign stable_d[j] = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_step) begin
      mask_q   <= mask_d;
      stable_q <= stable_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_mask_o     = mask_q;
  assign stable_pressed_o = stable_q;

  // --------------------------------------------------------------------------
  // Checks on the pipeline and the event selection.
  // --------------------------------------------------------------------------
  `MKD_ASSERT_SAME(a_stall_holds_item, out_valid_q && !out_ready_i, !s1_step,
    "item left the input register while the result was stalled")
  `MKD_ASSERT_NEXT(a_step_gives_result, s1_step, out_valid_o,
    "item left the input register without producing a result")
  `MKD_ASSERT_SAME(a_single_grant, s1_step, $onehot0(grant),
    "more than one key event granted by one read")
  `MKD_ASSERT_SAME(a_single_shot_held, s1_step && single_shot_q && (mask_d != '0),
    (mask_d & stable_d) == '0, "single-shot read reported a key still held down")

endmodule
